### rtl/mm4_pkg.sv
// Shared types, constants and arithmetic helpers for the 4x4 Q16.16 matrix multiplier.
// No dependencies; used by mm4_cell, mm4_out and matrix_multiply_4x4.
package mm4_pkg;

   localparam int FRAC_BITS = 16;
   localparam int DATA_W    = 32;
   localparam int PROD_W    = 2 * DATA_W;
   localparam int ACC_W     = PROD_W + 2;
   localparam int ROWS      = 4;
   localparam int COLS      = 4;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_MUL  = 1'b1;

   localparam logic [ACC_W-1:0]  ROUND_HALF = ACC_W'(1) << (FRAC_BITS - 1);
   localparam logic [DATA_W-1:0] SAT_MAX    = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic [DATA_W-1:0] SAT_MIN    = {1'b1, {(DATA_W-1){1'b0}}};

   typedef logic [ROWS-1:0][ACC_W-1:0]  acc_vec_type;
   typedef logic [ROWS-1:0][PROD_W-1:0] prod_vec_type;
   typedef logic [ROWS-1:0][DATA_W-1:0] data_vec_type;

   typedef struct packed {
      logic              valid;
      logic              op;
      logic [3:0]        load_index;
      logic [DATA_W-1:0] load_value;
      logic [1:0]        column_number;
      data_vec_type      right;
   } item_type;

   typedef struct packed {
      logic              ovf;
      logic [DATA_W-1:0] value;
   } sat_type;

   function automatic logic [PROD_W-1:0] mul_s32(input logic [DATA_W-1:0] a,
                                                 input logic [DATA_W-1:0] b);
      logic signed [PROD_W-1:0] ax;
      logic signed [PROD_W-1:0] bx;
      ax = $signed({{DATA_W{a[DATA_W-1]}}, a});
      bx = $signed({{DATA_W{b[DATA_W-1]}}, b});
      return PROD_W'(ax * bx);
   endfunction

   // acc already holds the rounding half; shift out the fraction and clamp.
   function automatic sat_type round_sat(input logic [ACC_W-1:0] acc);
      logic [ACC_W-1:0]        shifted;
      logic [ACC_W-DATA_W:0]   hi;
      sat_type                 res;
      shifted = ACC_W'($signed(acc) >>> FRAC_BITS);
      hi      = shifted[ACC_W-1:DATA_W-1];
      if ((&hi) || !(|hi)) begin
         res.ovf   = 1'b0;
         res.value = shifted[DATA_W-1:0];
      end else if (acc[ACC_W-1]) begin
         res.ovf   = 1'b1;
         res.value = SAT_MIN;
      end else begin
         res.ovf   = 1'b1;
         res.value = SAT_MAX;
      end
      return res;
   endfunction

endpackage

### rtl/matrix_multiply_4x4.sv
// Top level of the 4x4 Q16.16 column-major matrix multiplier.
// Depends on mm4_pkg, mm4_cell and mm4_out.
//
// Usage:
//   req channel: req_tuser is the op (0 load one left element, 1 multiply one
//   right column). A load writes load_value at column-major load_index and gives
//   no result. A multiply carries a right column and its column number and gives
//   one rsp transfer: the product column, rounded half up and saturated, with
//   rsp_tuser flagging saturation in any row.
//   Four cells in a chain, one per left column, each with four 32x32 multipliers
//   followed by a 66-bit add; loads travel the chain in order with multiplies, so
//   a multiply always sees every load accepted before it.
//   Throughput: one transfer per cycle while the receiver does not stall. A multiply
//   passes two register stages per cell, the first loaded at the accepting edge, and
//   then the output register before rsp_tvalid rises.
//   Reset clears the left matrix to zero and empties the chain.
//   When the receiver stalls with a result waiting, the whole chain holds and
//   req_tready drops in the same cycle; nothing is lost or reordered.
module matrix_multiply_4x4 (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // load_index[3:0], load_value[35:4], column_number[37:36], right_elem0[69:38],
   // right_elem1[101:70], right_elem2[133:102], right_elem3[165:134], zero[167:166]
   input  logic [167:0] req_tdata,
   // op[0]
   input  logic [0:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // product_column[1:0], product0[33:2], product1[65:34], product2[97:66],
   // product3[129:98], zero[135:130]
   output logic [135:0] rsp_tdata,
   // overflow[0]
   output logic [0:0]   rsp_tuser
);

   mm4_pkg::item_type     link [mm4_pkg::COLS+1];
   mm4_pkg::acc_vec_type  part [mm4_pkg::COLS+1];
   logic                  advance;
   logic [1:0]            rsp_column;
   mm4_pkg::data_vec_type rsp_prod;
   logic                  rsp_ovf;

   assign req_tready = advance;

   assign link[0].valid         = req_tvalid;
   assign link[0].op            = req_tuser[0];
   assign link[0].load_index    = req_tdata[3:0];
   assign link[0].load_value    = req_tdata[35:4];
   assign link[0].column_number = req_tdata[37:36];
   assign link[0].right[0]      = req_tdata[69:38];
   assign link[0].right[1]      = req_tdata[101:70];
   assign link[0].right[2]      = req_tdata[133:102];
   assign link[0].right[3]      = req_tdata[165:134];
   assign part[0]               = {mm4_pkg::ROWS{mm4_pkg::ROUND_HALF}};

   for (genvar g = 0; g < mm4_pkg::COLS; g++) begin : g_cell
      mm4_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .advance    (advance),
         .cell_index (2'(g)),
         .in_item    (link[g]),
         .in_part    (part[g]),
         .out_item   (link[g+1]),
         .out_part   (part[g+1])
      );
   end

   mm4_out u_out (
      .clock      (clock),
      .reset      (reset),
      .in_item    (link[mm4_pkg::COLS]),
      .in_acc     (part[mm4_pkg::COLS]),
      .rsp_tready (rsp_tready),
      .advance    (advance),
      .rsp_valid  (rsp_tvalid),
      .rsp_column (rsp_column),
      .rsp_prod   (rsp_prod),
      .rsp_ovf    (rsp_ovf)
   );

   assign rsp_tdata = {6'b0, rsp_prod[3], rsp_prod[2], rsp_prod[1], rsp_prod[0], rsp_column};
   assign rsp_tuser = rsp_ovf;

endmodule

### rtl/mm4_cell.sv
// One cell of the multiply chain: holds one left-matrix column, multiplies it by
// its right element and adds the four row products to the partial sums. Uses mm4_pkg.
module mm4_cell (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic [1:0]          cell_index,
   input  mm4_pkg::item_type   in_item,
   input  mm4_pkg::acc_vec_type in_part,
   output mm4_pkg::item_type   out_item,
   output mm4_pkg::acc_vec_type out_part
);

   mm4_pkg::data_vec_type  left_ff, left_in;
   mm4_pkg::item_type      s1_item_ff, s1_item_in;
   mm4_pkg::prod_vec_type  s1_prod_ff, s1_prod_in;
   mm4_pkg::acc_vec_type   s1_part_ff;
   mm4_pkg::item_type      s2_item_ff;
   mm4_pkg::acc_vec_type   s2_acc_ff, s2_acc_in;
   logic [mm4_pkg::DATA_W-1:0] right_sel;
   logic                   wr_en;

   assign right_sel = in_item.right[cell_index];
   assign wr_en = advance && in_item.valid && (in_item.op == mm4_pkg::OP_LOAD)
                  && (in_item.load_index[3:2] == cell_index);

   always_comb begin
      left_in = left_ff;
      if (wr_en) begin
         left_in[in_item.load_index[1:0]] = in_item.load_value;
      end
      s1_item_in = in_item;
      for (int r = 0; r < mm4_pkg::ROWS; r++) begin
         s1_prod_in[r] = mm4_pkg::mul_s32(left_ff[r], right_sel);
      end
      for (int r = 0; r < mm4_pkg::ROWS; r++) begin
         s2_acc_in[r] = s1_part_ff[r]
                        + {{2{s1_prod_ff[r][mm4_pkg::PROD_W-1]}}, s1_prod_ff[r]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff          <= '0;
         s1_item_ff.valid <= 1'b0;
         s2_item_ff.valid <= 1'b0;
      end else if (advance) begin
         left_ff    <= left_in;
         s1_item_ff <= s1_item_in;
         s2_item_ff <= s1_item_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_prod_ff <= s1_prod_in;
         s1_part_ff <= in_part;
         s2_acc_ff  <= s2_acc_in;
      end
   end

   assign out_item = s2_item_ff;
   assign out_part = s2_acc_ff;

   a_load_written: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> left_ff[$past(in_item.load_index[1:0])] == $past(in_item.load_value))
      else $error("left element not written by load transfer");

   a_zero_column: assert property (@(posedge clock) disable iff (reset)
      (advance && in_item.valid && (in_item.op == mm4_pkg::OP_MUL) && (right_sel == '0))
      |=> (s1_prod_ff == '0))
      else $error("zero right element gave nonzero products");

endmodule

### rtl/mm4_out.sv
// Output stage: rounds, shifts and saturates the chain's sums and holds the result
// until the receiver takes it; drives the chain's advance enable. Uses mm4_pkg.
module mm4_out (
   input  logic                 clock,
   input  logic                 reset,
   input  mm4_pkg::item_type    in_item,
   input  mm4_pkg::acc_vec_type in_acc,
   input  logic                 rsp_tready,
   output logic                 advance,
   output logic                 rsp_valid,
   output logic [1:0]           rsp_column,
   output mm4_pkg::data_vec_type rsp_prod,
   output logic                 rsp_ovf
);

   logic                  valid_ff, valid_in;
   logic [1:0]            column_ff;
   mm4_pkg::data_vec_type prod_ff, prod_in;
   logic                  ovf_ff, ovf_in;
   mm4_pkg::sat_type      sat_row [mm4_pkg::ROWS];

   assign advance  = !valid_ff || rsp_tready;
   assign valid_in = in_item.valid && (in_item.op == mm4_pkg::OP_MUL);

   always_comb begin
      ovf_in = 1'b0;
      for (int r = 0; r < mm4_pkg::ROWS; r++) begin
         sat_row[r] = mm4_pkg::round_sat(in_acc[r]);
         prod_in[r] = sat_row[r].value;
         ovf_in     = ovf_in | sat_row[r].ovf;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         column_ff <= in_item.column_number;
         prod_ff   <= prod_in;
         ovf_ff    <= ovf_in;
      end
   end

   assign rsp_valid  = valid_ff;
   assign rsp_column = column_ff;
   assign rsp_prod   = prod_ff;
   assign rsp_ovf    = ovf_ff;

   a_ovf_means_clamp: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && ovf_ff) |->
         (prod_ff[0] == mm4_pkg::SAT_MAX || prod_ff[0] == mm4_pkg::SAT_MIN ||
          prod_ff[1] == mm4_pkg::SAT_MAX || prod_ff[1] == mm4_pkg::SAT_MIN ||
          prod_ff[2] == mm4_pkg::SAT_MAX || prod_ff[2] == mm4_pkg::SAT_MIN ||
          prod_ff[3] == mm4_pkg::SAT_MAX || prod_ff[3] == mm4_pkg::SAT_MIN))
      else $error("overflow flagged without a clamped row");

   a_only_multiply: assert property (@(posedge clock) disable iff (reset)
      $rose(valid_ff) |-> $past(in_item.valid && (in_item.op == mm4_pkg::OP_MUL)))
      else $error("result raised without a multiply transfer");

endmodule
